### sv/hpet_pkg.sv
// Shared types, widths, register map and reset values of the HPET timer block.
// Used by hpet_tmr, hpet_timer_block and its checker; depends on nothing else.
package hpet_pkg;

    localparam int DATA_W         = 64;
    localparam int ADDR_W         = 10;
    localparam int CMD_W          = 2;
    localparam int IRQ_W          = 3;
    localparam int ROUTE_W        = 5;
    localparam int CLK_PER_W      = 27;
    localparam int PER_CAP_W      = 3;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int TMR_IDX_W      = 5;
    localparam int TMR_OFF_W      = 5;
    localparam int NUM_TIMERS_DEF = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd;

    // register byte offsets
    localparam logic [ADDR_W-1:0] REG_CAP     = 10'h000;
    localparam logic [ADDR_W-1:0] REG_GENCONF = 10'h010;
    localparam logic [ADDR_W-1:0] REG_STATUS  = 10'h020;
    localparam logic [ADDR_W-1:0] REG_COUNTER = 10'h0F0;
    localparam logic [ADDR_W-1:0] TIMER_BASE  = 10'h100;
    localparam logic [TMR_OFF_W-1:0] TMR_OFF_CFG = 5'h00;
    localparam logic [TMR_OFF_W-1:0] TMR_OFF_CMP = 5'h08;

    localparam logic [7:0] HPET_REV = 8'h01;

    // configuration port register indexes
    localparam logic CFG_CLK_PERIOD = 1'b0;
    localparam logic CFG_PER_CAP    = 1'b1;

    localparam logic [CLK_PER_W-1:0] CLK_PERIOD_RST = 27'd69841279;
    localparam logic [PER_CAP_W-1:0] PER_CAP_RST    = 3'd7;

    typedef struct packed {
        logic              tick;
        logic              cfg_we;
        logic              cmp_we;
        logic [DATA_W-1:0] wdata;
    } t_tmr_req;

    typedef struct packed {
        logic              fire;
        logic [DATA_W-1:0] cfg_rd;
        logic [DATA_W-1:0] cmp;
    } t_tmr_rsp;

endpackage

### sv/hpet_timer_block.sv
// Top level of the HPET timer block: request pipeline, global registers, timer lanes.
// Depends on hpet_pkg and hpet_tmr.
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_stall    i_cmd, i_addr, i_wdata
//   result    out        o_out_valid / i_out_stall  o_rdata, o_irq_fire
//   config    in         APB psel/penable/pready    paddr, pwdata, prdata
//
// One request per cycle unless o_in_stall is high; a request passes through the input
// register, then the result register. Timer and global state change as a request moves
// from the input register into the result register, so requests act strictly in order.
// Synchronous active-low reset empties the pipeline and resets all timer and global state.
// A stalled result holds the result register; o_in_stall rises only when the input
// register is full and the result register cannot drain.
module hpet_timer_block #(
    parameter int NUM_TIMERS = hpet_pkg::NUM_TIMERS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [hpet_pkg::CMD_W-1:0]        i_cmd,
    input  logic [hpet_pkg::ADDR_W-1:0]       i_addr,
    input  logic [hpet_pkg::DATA_W-1:0]       i_wdata,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [hpet_pkg::DATA_W-1:0]       o_rdata,
    output logic [hpet_pkg::IRQ_W-1:0]        o_irq_fire,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hpet_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hpet_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hpet_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import hpet_pkg::*;

    localparam logic [ROUTE_W-1:0] LAST_TMR = ROUTE_W'(NUM_TIMERS - 1);

    // configuration registers
    logic [CLK_PER_W-1:0] r_clk_period, n_clk_period;
    logic [PER_CAP_W-1:0] r_per_cap, n_per_cap;
    logic                 w_cfg_wr;

    // pipeline
    logic              r_in_valid, n_in_valid;
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_wdata;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_rdata, n_rdata;
    logic [IRQ_W-1:0]  r_irq, n_irq;
    logic              w_out_free;
    logic              w_in_acc;
    logic              w_proc;

    // global state
    logic [DATA_W-1:0]     r_counter, n_counter;
    logic                  r_gen_en, n_gen_en;
    logic [NUM_TIMERS-1:0] r_status, n_status;

    // decode
    logic [ADDR_W-1:0]     w_a;
    logic [ADDR_W-1:0]     w_tmr_rel;
    logic [TMR_IDX_W-1:0]  w_tmr_n;
    logic [TMR_OFF_W-1:0]  w_tmr_off;
    logic                  w_is_tmr;
    logic                  w_tick;
    logic                  w_wr;
    logic [DATA_W-1:0]     w_count_nxt;
    logic [NUM_TIMERS-1:0] w_sel;
    logic [NUM_TIMERS-1:0] w_fire;
    logic [IRQ_W-1:0]      w_irq;
    logic [DATA_W-1:0]     w_tmr_rd;
    logic [DATA_W-1:0]     w_rd_val;
    t_tmr_req              w_req [NUM_TIMERS];
    t_tmr_rsp              w_rsp [NUM_TIMERS];

    //------------------------------------------------------------------
    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        n_clk_period = r_clk_period;
        n_per_cap    = r_per_cap;
        if (w_cfg_wr) begin
            case (paddr[2])
                CFG_CLK_PERIOD: n_clk_period = pwdata[CLK_PER_W-1:0];
                CFG_PER_CAP:    n_per_cap    = pwdata[PER_CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_CLK_PERIOD: prdata = APB_DATA_W'(r_clk_period);
            CFG_PER_CAP:    prdata = APB_DATA_W'(r_per_cap);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_period <= CLK_PERIOD_RST;
            r_per_cap    <= PER_CAP_RST;
        end else begin
            r_clk_period <= n_clk_period;
            r_per_cap    <= n_per_cap;
        end
    end

    //------------------------------------------------------------------
    // handshake and pipeline control
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = r_in_valid & ~w_out_free;
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_proc     = r_in_valid & w_out_free;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_acc) begin
            n_in_valid = 1'b1;
        end else if (w_proc) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_proc) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_addr  <= i_addr;
            r_wdata <= i_wdata;
        end
        r_rdata <= n_rdata;
        r_irq   <= n_irq;
    end

    //------------------------------------------------------------------
    // address decode, low three bits dropped
    assign w_a         = {r_addr[ADDR_W-1:3], 3'b000};
    assign w_is_tmr    = (w_a >= TIMER_BASE);
    assign w_tmr_rel   = w_a - TIMER_BASE;
    assign w_tmr_n     = w_tmr_rel[ADDR_W-1:TMR_OFF_W];
    assign w_tmr_off   = w_tmr_rel[TMR_OFF_W-1:0];
    assign w_tick      = w_proc & (r_cmd == CMD_TICK) & r_gen_en;
    assign w_wr        = w_proc & (r_cmd == CMD_WRITE);
    assign w_count_nxt = r_counter + DATA_W'(1);

    //------------------------------------------------------------------
    // timer lanes
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
        logic w_lane_cap;

        if (g < PER_CAP_W) begin : g_cap
            assign w_lane_cap = r_per_cap[g];
        end else begin : g_nocap
            assign w_lane_cap = 1'b0;
        end

        assign w_sel[g]        = w_is_tmr & (w_tmr_n == TMR_IDX_W'(g));
        assign w_req[g].tick   = w_tick;
        assign w_req[g].cfg_we = w_wr & w_sel[g] & (w_tmr_off == TMR_OFF_CFG);
        assign w_req[g].cmp_we = w_wr & w_sel[g] & (w_tmr_off == TMR_OFF_CMP);
        assign w_req[g].wdata  = r_wdata;
        assign w_fire[g]       = w_rsp[g].fire;

        hpet_tmr u_tmr (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_req       (w_req[g]),
            .i_count_nxt (w_count_nxt),
            .i_per_cap   (w_lane_cap),
            .o_rsp       (w_rsp[g])
        );
    end

    // fire bits of timers past the irq width are dropped
    for (genvar g = 0; g < IRQ_W; g++) begin : g_irq
        if (g < NUM_TIMERS) begin : g_on
            assign w_irq[g] = w_fire[g];
        end else begin : g_off
            assign w_irq[g] = 1'b0;
        end
    end

    //------------------------------------------------------------------
    // read data
    always_comb begin
        w_tmr_rd = '0;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            if (w_sel[k]) begin
                if (w_tmr_off == TMR_OFF_CFG) begin
                    w_tmr_rd = w_rsp[k].cfg_rd;
                end else if (w_tmr_off == TMR_OFF_CMP) begin
                    w_tmr_rd = w_rsp[k].cmp;
                end
            end
        end
    end

    always_comb begin
        case (w_a)
            REG_CAP:     w_rd_val = {5'b0, r_clk_period, 18'b0, 1'b1, LAST_TMR, HPET_REV};
            REG_GENCONF: w_rd_val = DATA_W'(r_gen_en);
            REG_STATUS:  w_rd_val = DATA_W'(r_status);
            REG_COUNTER: w_rd_val = r_counter;
            default:     w_rd_val = w_is_tmr ? w_tmr_rd : '0;
        endcase
    end

    always_comb begin
        n_rdata = r_rdata;
        n_irq   = r_irq;
        if (w_proc) begin
            n_rdata = (r_cmd == CMD_READ) ? w_rd_val : '0;
            n_irq   = w_irq;
        end
    end

    //------------------------------------------------------------------
    // global state
    always_comb begin
        n_counter = r_counter;
        n_gen_en  = r_gen_en;
        n_status  = r_status | w_fire;
        if (w_tick) begin
            n_counter = w_count_nxt;
        end
        if (w_wr) begin
            case (w_a)
                REG_GENCONF: n_gen_en  = r_wdata[0];
                REG_STATUS:  n_status  = r_status & ~r_wdata[NUM_TIMERS-1:0];
                REG_COUNTER: n_counter = r_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_gen_en  <= 1'b0;
            r_status  <= '0;
        end else begin
            r_counter <= n_counter;
            r_gen_en  <= n_gen_en;
            r_status  <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rdata     = r_rdata;
    assign o_irq_fire  = r_irq;

endmodule

### sv/hpet_tmr.sv
// One HPET timer: control bits, comparator and period, with match on tick.
// Depends on hpet_pkg for the request and response structs.
module hpet_tmr (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hpet_pkg::t_tmr_req            i_req,
    input  logic [hpet_pkg::DATA_W-1:0]   i_count_nxt,
    input  logic                          i_per_cap,
    output hpet_pkg::t_tmr_rsp            o_rsp
);
    import hpet_pkg::*;

    logic               r_enb, n_enb;
    logic               r_per, n_per;
    logic               r_valset, n_valset;
    logic [ROUTE_W-1:0] r_route, n_route;
    logic [DATA_W-1:0]  r_cmp, n_cmp;
    logic [DATA_W-1:0]  r_period, n_period;
    logic               w_match;

    assign w_match = (r_cmp == i_count_nxt);

    always_comb begin
        n_enb    = r_enb;
        n_per    = r_per;
        n_valset = r_valset;
        n_route  = r_route;
        n_cmp    = r_cmp;
        n_period = r_period;
        if (i_req.cfg_we) begin
            n_enb    = i_req.wdata[2];
            n_per    = i_req.wdata[3] & i_per_cap;
            n_valset = i_req.wdata[6];
            n_route  = i_req.wdata[13:9];
        end else if (i_req.cmp_we) begin
            if (r_per) begin
                n_period = i_req.wdata;
                if (r_valset) begin
                    n_cmp = i_req.wdata;
                end
            end else begin
                n_cmp = i_req.wdata;
            end
            n_valset = 1'b0;
        end else if (i_req.tick && w_match && r_per) begin
            // reload for the next period, wraps mod 2^64
            n_cmp = r_cmp + r_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enb    <= 1'b0;
            r_per    <= 1'b0;
            r_valset <= 1'b0;
            r_route  <= '0;
            r_cmp    <= '1;
            r_period <= '0;
        end else begin
            r_enb    <= n_enb;
            r_per    <= n_per;
            r_valset <= n_valset;
            r_route  <= n_route;
            r_cmp    <= n_cmp;
            r_period <= n_period;
        end
    end

    assign o_rsp.fire   = i_req.tick & w_match & r_enb;
    assign o_rsp.cmp    = r_cmp;
    assign o_rsp.cfg_rd = {32'hFFFF_FFFF, 18'b0, r_route, 2'b00, r_valset, 1'b1,
                           i_per_cap, r_per, r_enb, 2'b00};

endmodule

### sv/hpet_timer_block_chk.sv
// Port-level checker for hpet_timer_block, attached by the bind at the bottom.
// Depends on hpet_pkg for widths.
module hpet_timer_block_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [hpet_pkg::DATA_W-1:0]  o_rdata,
    input logic [hpet_pkg::IRQ_W-1:0]   o_irq_fire
);
    import hpet_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rdata) && $stable(o_irq_fire))
        else $error("stalled result changed");

    // a tick never returns read data
    a_fire_no_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_irq_fire != '0) |-> (o_rdata == '0))
        else $error("fire and read data in one result");

    // never stall requests while the result side is empty
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("request stalled with empty result register");

    // drop the result after reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind hpet_timer_block hpet_timer_block_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_rdata     (o_rdata),
    .o_irq_fire  (o_irq_fire)
);

### bench/hpet_timer_block_tb.sv
// Self-checking bench for hpet_timer_block: random ticks and register requests
// with bursty input and stalled output, checked against a shadow of the timer state.
// Depends on hpet_pkg and the hpet_timer_block RTL.
module hpet_timer_block_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hpet_pkg::*;

    localparam int NTMR = NUM_TIMERS_DEF;
    localparam int PHASE_ITEMS = 112;

    // Shadow of the block's registers; predicts one result per request.
    class hpet_shadow;
        typedef struct {
            logic [DATA_W-1:0] rdata;
            logic [IRQ_W-1:0]  fire;
        } t_result;

        t_result due[$];
        int mismatches;

        bit [CLK_PER_W-1:0] clk_period;
        bit [PER_CAP_W-1:0] per_cap;
        bit [DATA_W-1:0]    counter;
        bit                 gen_en;
        bit                 t_en [NTMR];
        bit                 t_per [NTMR];
        bit                 t_vset [NTMR];
        bit [ROUTE_W-1:0]   t_route [NTMR];
        bit [DATA_W-1:0]    t_cmp [NTMR];
        bit [DATA_W-1:0]    t_period [NTMR];
        bit [31:0]          int_status;

        function new();
            clk_period = CLK_PERIOD_RST;
            per_cap    = PER_CAP_RST;
            counter    = '0;
            gen_en     = 1'b0;
            int_status = '0;
            mismatches = 0;
            for (int n = 0; n < NTMR; n++) begin
                t_en[n]     = 1'b0;
                t_per[n]    = 1'b0;
                t_vset[n]   = 1'b0;
                t_route[n]  = '0;
                t_cmp[n]    = '1;
                t_period[n] = '0;
            end
        endfunction

        function void set_cfg(logic idx, logic [31:0] val);
            if (idx == CFG_CLK_PERIOD) clk_period = val[CLK_PER_W-1:0];
            else per_cap = val[PER_CAP_W-1:0];
        endfunction

        function bit per_capable(int n);
            return n < 3 && per_cap[n];
        endfunction

        function bit [DATA_W-1:0] read_reg(bit [ADDR_W-1:0] a);
            bit [ADDR_W-1:0] rel;
            bit [DATA_W-1:0] v;
            int n;
            v = '0;
            if (a == REG_CAP)
                v = {5'b0, clk_period, 18'b0, 1'b1, 5'(NTMR - 1), HPET_REV};
            else if (a == REG_GENCONF) v = {63'b0, gen_en};
            else if (a == REG_STATUS) v = {32'b0, int_status};
            else if (a == REG_COUNTER) v = counter;
            else if (a >= TIMER_BASE) begin
                rel = a - TIMER_BASE;
                n = int'(rel[ADDR_W-1:TMR_OFF_W]);
                if (n < NTMR && rel[TMR_OFF_W-1:0] == TMR_OFF_CFG) begin
                    v = 64'hFFFF_FFFF_0000_0020;
                    v[2] = t_en[n];
                    v[3] = t_per[n];
                    v[4] = per_capable(n);
                    v[6] = t_vset[n];
                    v[13:9] = t_route[n];
                end else if (n < NTMR && rel[TMR_OFF_W-1:0] == TMR_OFF_CMP) begin
                    v = t_cmp[n];
                end
            end
            return v;
        endfunction

        function void write_reg(bit [ADDR_W-1:0] a, bit [DATA_W-1:0] v);
            bit [ADDR_W-1:0] rel;
            int n;
            if (a == REG_GENCONF) gen_en = v[0];
            else if (a == REG_STATUS) int_status &= ~v[31:0];
            else if (a == REG_COUNTER) counter = v;
            else if (a >= TIMER_BASE) begin
                rel = a - TIMER_BASE;
                n = int'(rel[ADDR_W-1:TMR_OFF_W]);
                if (n < NTMR && rel[TMR_OFF_W-1:0] == TMR_OFF_CFG) begin
                    t_en[n]    = v[2];
                    t_per[n]   = v[3] && per_capable(n);
                    t_vset[n]  = v[6];
                    t_route[n] = v[13:9];
                end else if (n < NTMR && rel[TMR_OFF_W-1:0] == TMR_OFF_CMP) begin
                    if (t_per[n]) begin
                        t_period[n] = v;
                        if (t_vset[n]) t_cmp[n] = v;
                    end else begin
                        t_cmp[n] = v;
                    end
                    t_vset[n] = 1'b0;
                end
            end
        endfunction

        function bit [IRQ_W-1:0] tick();
            bit [IRQ_W-1:0] fire;
            fire = '0;
            if (gen_en) begin
                counter = counter + 64'd1;
                for (int n = 0; n < NTMR; n++) begin
                    if (t_cmp[n] == counter) begin
                        if (t_en[n]) begin
                            if (n < IRQ_W) fire[n] = 1'b1;
                            int_status[n] = 1'b1;
                        end
                        if (t_per[n]) t_cmp[n] = t_cmp[n] + t_period[n];
                    end
                end
            end
            return fire;
        endfunction

        function void take_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                   logic [DATA_W-1:0] wdata);
            t_result r;
            bit [ADDR_W-1:0] a;
            a = {addr[ADDR_W-1:3], 3'b000};
            r.rdata = '0;
            r.fire  = '0;
            if (cmd == CMD_TICK) r.fire = tick();
            else if (cmd == CMD_READ) r.rdata = read_reg(a);
            else if (cmd == CMD_WRITE) write_reg(a, wdata);
            due.push_back(r);
        endfunction

        function void report(string what, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] act);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h got %h", what, exp, act);
        endfunction

        function void match_result(logic [DATA_W-1:0] rdata, logic [IRQ_W-1:0] fire);
            t_result r;
            if (due.size() == 0) begin
                report("unrequested result", '0, rdata);
                return;
            end
            r = due.pop_front();
            if (rdata !== r.rdata) report("rdata", r.rdata, rdata);
            if (fire !== r.fire) report("irq_fire", {61'b0, r.fire}, {61'b0, fire});
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CMD_W-1:0]      cmd = '0;
    logic [ADDR_W-1:0]     addr = '0;
    logic [DATA_W-1:0]     wdata = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DATA_W-1:0]     rdata;
    logic [IRQ_W-1:0]      irq_fire;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hpet_timer_block uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_cmd       (cmd),
        .i_addr      (addr),
        .i_wdata     (wdata),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_rdata     (rdata),
        .o_irq_fire  (irq_fire),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    hpet_shadow sb = new();

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Output stall: switch between free, light and heavy back-pressure.
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(2);
            stall_left = $urandom_range(8, 80);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(3) == 0);
            default: out_stall <= ($urandom_range(1) == 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.match_result(rdata, irq_fire);
    end

    int burst_left = 0;

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] tmr_addr(int n, logic [TMR_OFF_W-1:0] off);
        logic [TMR_OFF_W-1:0] idx;
        idx = TMR_OFF_W'(n);
        return TIMER_BASE + {idx, off};
    endfunction

    // Present one request at a falling edge and hold it until accepted.
    task automatic send_req(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(15) == 0) gap = $urandom_range(10, 30);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid = 1'b1;
        cmd      = c;
        addr     = a;
        wdata    = d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.take_request(c, a, d);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic quiesce();
        in_valid = 1'b0;
        burst_left = 0;
        while (sb.due.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(logic idx, logic [31:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_cfg(idx, val);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Arm a timer relative to the current count: config, comparator, optional period.
    task automatic program_timer();
        int n;
        logic [DATA_W-1:0] cfg;
        n = $urandom_range(0, NTMR - 1);
        cfg = rand64();
        cfg[2] = ($urandom_range(3) != 0);
        cfg[3] = 1'($urandom_range(1));
        cfg[6] = 1'b1;
        send_req(CMD_WRITE, tmr_addr(n, TMR_OFF_CFG), cfg);
        send_req(CMD_WRITE, tmr_addr(n, TMR_OFF_CMP), sb.counter + 64'($urandom_range(1, 10)));
        if ($urandom_range(1))
            send_req(CMD_WRITE, tmr_addr(n, TMR_OFF_CMP), 64'($urandom_range(1, 8)));
    endtask

    task automatic random_read();
        int sel;
        logic [ADDR_W-1:0] a;
        sel = $urandom_range(0, 3 + 2 * NTMR);
        case (sel)
            0: a = REG_CAP;
            1: a = REG_GENCONF;
            2: a = REG_STATUS;
            3: a = REG_COUNTER;
            default: a = tmr_addr((sel - 4) / 2, ((sel - 4) % 2) ? TMR_OFF_CMP : TMR_OFF_CFG);
        endcase
        a[2:0] = 3'($urandom_range(7));
        send_req(CMD_READ, a, rand64());
    endtask

    task automatic random_write();
        logic [DATA_W-1:0] d;
        int n;
        n = $urandom_range(0, NTMR - 1);
        d = rand64();
        case ($urandom_range(5))
            0: begin
                d[0] = ($urandom_range(7) != 0);
                send_req(CMD_WRITE, REG_GENCONF, d);
            end
            1: begin
                d[2] = ($urandom_range(3) != 0);
                send_req(CMD_WRITE, tmr_addr(n, TMR_OFF_CFG), d);
            end
            2: send_req(CMD_WRITE, REG_STATUS, d);
            3: begin
                if ($urandom_range(1))
                    d = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 6));
                else d = 64'($urandom_range(0, 1000));
                send_req(CMD_WRITE, REG_COUNTER, d);
            end
            default: begin
                if ($urandom_range(7) != 0) d = sb.counter + 64'($urandom_range(1, 16));
                send_req(CMD_WRITE, tmr_addr(n, TMR_OFF_CMP), d);
            end
        endcase
    endtask

    task automatic random_phase(int items);
        int done;
        int pick;
        int k;
        done = 0;
        while (done < items) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                program_timer();
                done += 3;
            end else if (pick < 50) begin
                k = $urandom_range(1, 6);
                repeat (k) send_req(CMD_TICK, 10'($urandom_range(1023)), rand64());
                done += k;
            end else if (pick < 62) begin
                random_read();
                done++;
            end else if (pick < 85) begin
                random_write();
                done++;
            end else begin
                // noise: any command, any address, any data
                send_req(2'($urandom_range(3)), 10'($urandom_range(1023)), rand64());
                done++;
            end
        end
    endtask

    // Try periodic mode on every timer, then read back what stuck.
    task automatic probe_periodic();
        for (int n = 0; n < NTMR; n++) begin
            send_req(CMD_WRITE, tmr_addr(n, TMR_OFF_CFG), 64'h0000_0000_0000_000C);
            send_req(CMD_READ, tmr_addr(n, TMR_OFF_CFG), '0);
        end
    endtask

    task automatic directed_part();
        send_req(CMD_READ, REG_CAP, '0);
        send_req(CMD_READ, REG_CAP | 10'h007, '1);
        // halted counter
        send_req(CMD_TICK, '0, '0);
        send_req(CMD_WRITE, REG_GENCONF, '1);
        send_req(CMD_READ, REG_GENCONF, '0);
        send_req(CMD_WRITE, tmr_addr(0, TMR_OFF_CFG), 64'h0000_0000_0000_3E4C);
        send_req(CMD_WRITE, tmr_addr(0, TMR_OFF_CMP), 64'd3);
        send_req(CMD_WRITE, tmr_addr(0, TMR_OFF_CMP), 64'd2);
        send_req(CMD_READ, tmr_addr(0, TMR_OFF_CFG), '0);
        repeat (4) send_req(CMD_TICK, '0, '0);
        // wrap the counter
        send_req(CMD_WRITE, REG_COUNTER, 64'hFFFF_FFFF_FFFF_FFFE);
        send_req(CMD_WRITE, tmr_addr(1, TMR_OFF_CFG), '1);
        send_req(CMD_WRITE, tmr_addr(1, TMR_OFF_CMP), '0);
        send_req(CMD_WRITE, tmr_addr(2, TMR_OFF_CFG), 64'h0000_0000_0000_0004);
        send_req(CMD_TICK, '0, '0);
        send_req(CMD_TICK, '0, '0);
        send_req(CMD_READ, REG_STATUS, '0);
        send_req(CMD_WRITE, REG_STATUS, '1);
        // absent timer, FSB route, unmapped, unknown command
        send_req(CMD_WRITE, tmr_addr(NTMR, TMR_OFF_CMP), '1);
        send_req(CMD_READ, tmr_addr(NTMR, TMR_OFF_CFG), '0);
        send_req(CMD_WRITE, TIMER_BASE | 10'h010, '1);
        send_req(CMD_READ, TIMER_BASE | 10'h010, '0);
        send_req(2'd3, 10'h3FF, '1);
        send_req(CMD_READ, 10'h3F8, '0);
        send_req(CMD_READ, REG_COUNTER, '0);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_part();
        random_phase(PHASE_ITEMS - 25);

        quiesce();
        apb_write(CFG_CLK_PERIOD, 32'd1);
        apb_write(CFG_PER_CAP, 32'd0);
        probe_periodic();
        random_phase(PHASE_ITEMS);

        quiesce();
        apb_write(CFG_CLK_PERIOD, 32'd100000000);
        apb_write(CFG_PER_CAP, 32'd7);
        probe_periodic();
        random_phase(PHASE_ITEMS);

        quiesce();
        apb_write(CFG_CLK_PERIOD, $urandom_range(1, 100000000));
        apb_write(CFG_PER_CAP, $urandom_range(0, 7));
        probe_periodic();
        send_req(CMD_READ, REG_CAP, '0);
        random_phase(PHASE_ITEMS);

        quiesce();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
sv/hpet_pkg.sv
sv/hpet_tmr.sv
sv/hpet_timer_block.sv
sv/hpet_timer_block_chk.sv
bench/hpet_timer_block_tb.sv
